/* hdl/pbtt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pbtt_pkg;

	localparam int NumEntriesDefault  = 32;
	localparam int VersionBitsDefault = 32;

	localparam logic [2:0] MODE_SET_SRC   = 3'd0;
	localparam logic [2:0] MODE_SET_TGT   = 3'd1;
	localparam logic [2:0] MODE_SET_COND  = 3'd2;
	localparam logic [2:0] MODE_QRY_FETCH = 3'd3;
	localparam logic [2:0] MODE_QRY_FINAL = 3'd4;
	localparam logic [2:0] MODE_COPY      = 3'd5;

	localparam logic [2:0] COND_NONE  = 3'd0;
	localparam logic [2:0] COND_TAKEN = 3'd1;
	localparam logic [2:0] COND_LOOP  = 3'd2;
	localparam logic [2:0] COND_BITS  = 3'd3;
	localparam logic [2:0] COND_CLEAR = 3'd4;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_TAKEN = 2'd1;
	localparam logic [1:0] KIND_LOOP  = 2'd2;
	localparam logic [1:0] KIND_BITS  = 2'd3;

	localparam logic [1:0] OUT_NONE      = 2'd0;
	localparam logic [1:0] OUT_TAKEN     = 2'd1;
	localparam logic [1:0] OUT_NOT_TAKEN = 2'd2;
	localparam logic [1:0] OUT_EXHAUSTED = 2'd3;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_KIND  = 2'd1;
	localparam logic [1:0] ERR_COUNT = 2'd2;

	localparam logic [3:0] INSTR_BYTES_RESET = 4'd4;

	typedef struct packed {
		logic        en;
		logic [2:0]  mode;
		logic [4:0]  reg_index;
		logic [63:0] address;
		logic [2:0]  condition_kind;
		logic [63:0] condition_value;
		logic [6:0]  bit_count;
	} cmd_t;

	typedef struct packed {
		logic        found;
		logic [1:0]  outcome;
		logic [4:0]  matched_reg;
		logic [31:0] version;
		logic [63:0] target;
	} hit_t;

endpackage
`default_nettype wire

/* hdl/precomputed_branch_target_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// Branch target table with a fetch map and a final map, built as a row of NUM_ENTRIES cells,
// one per branch register, each holding both copies. For every item, the query
// address is compared in all cells at once and the first hit passes down the row to the end,
// where the result is registered and offered in the cycle after the item is taken. While a
// result waits, the input is held off; the next item is taken in the same cycle as the waiting
// result leaves, so the rate is one item per cycle unless the output stalls.
module precomputed_branch_target_table #(
	parameter int NUM_ENTRIES  = pbtt_pkg::NumEntriesDefault,
	parameter int VERSION_BITS = pbtt_pkg::VersionBitsDefault
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [2:0]   paddr,
	input  wire  [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  wire          s_tvalid,
	output logic         s_tready,
	// reg_index[4:0], address[68:5], condition_kind[71:69], condition_value[135:72],
	// bit_count[142:136]
	input  wire  [143:0] s_tdata,
	// mode[2:0]
	input  wire  [2:0]   s_tuser,
	output logic         m_tvalid,
	input  wire          m_tready,
	// matched_reg[4:0], entry_version[36:5], next_address[100:37], error[102:101]
	output logic [103:0] m_tdata,
	// outcome[1:0]
	output logic [1:0]   m_tuser
);

	logic [3:0]     ib_q;
	logic           valid_q;
	logic [103:0]   data_q;
	logic [1:0]     user_q;
	pbtt_pkg::cmd_t cmd;
	pbtt_pkg::hit_t chain [NUM_ENTRIES+1];
	logic [NUM_ENTRIES-1:0] err_cnt;
	logic [63:0]    seq_addr;
	logic [63:0]    next_addr;
	logic [1:0]     r_outcome;
	logic [4:0]     r_reg;
	logic [31:0]    r_ver;
	logic [1:0]     r_err;
	logic           is_query;

	assign pready   = 1'b1;
	assign prdata   = paddr[2] ? 32'd0 : {28'd0, ib_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ib_q <= pbtt_pkg::INSTR_BYTES_RESET;
		else if (psel && penable && pwrite && !paddr[2])
			ib_q <= pwdata[3:0];
	end

	assign s_tready = !valid_q || m_tready;

	assign cmd.en              = s_tvalid && s_tready;
	assign cmd.mode            = s_tuser;
	assign cmd.reg_index       = s_tdata[4:0];
	assign cmd.address         = s_tdata[68:5];
	assign cmd.condition_kind  = s_tdata[71:69];
	assign cmd.condition_value = s_tdata[135:72];
	assign cmd.bit_count       = s_tdata[142:136];

	assign chain[0] = '0;

	for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
		pbtt_cell #(
			.IDX          (i),
			.VERSION_BITS (VERSION_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.hit_in    (chain[i]),
			.hit_out   (chain[i+1]),
			.err_count (err_cnt[i])
		);
	end

	assign is_query = (cmd.mode == pbtt_pkg::MODE_QRY_FETCH)
		|| (cmd.mode == pbtt_pkg::MODE_QRY_FINAL);
	assign seq_addr = cmd.address + 64'(ib_q);

	always_comb begin
		r_outcome = pbtt_pkg::OUT_NONE;
		r_reg     = '0;
		r_ver     = '0;
		next_addr = '0;
		r_err     = pbtt_pkg::ERR_OK;
		if (is_query) begin
			next_addr = seq_addr;
			if (chain[NUM_ENTRIES].found) begin
				r_outcome = chain[NUM_ENTRIES].outcome;
				r_reg     = chain[NUM_ENTRIES].matched_reg;
				r_ver     = chain[NUM_ENTRIES].version;
				if (chain[NUM_ENTRIES].outcome == pbtt_pkg::OUT_TAKEN)
					next_addr = chain[NUM_ENTRIES].target;
			end
		end else if (cmd.mode == pbtt_pkg::MODE_SET_COND) begin
			if (cmd.condition_kind > pbtt_pkg::COND_BITS)
				r_err = pbtt_pkg::ERR_KIND;
			else if (|err_cnt)
				r_err = pbtt_pkg::ERR_COUNT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (s_tready)
			valid_q <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			data_q <= {1'b0, r_err, next_addr, r_ver, r_reg};
			user_q <= r_outcome;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

endmodule
`default_nettype wire

/* hdl/pbtt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module pbtt_cell #(
	parameter int IDX          = 0,
	parameter int VERSION_BITS = pbtt_pkg::VersionBitsDefault
) (
	input  wire              clk,
	input  wire              arst_n,
	input  pbtt_pkg::cmd_t   cmd,
	input  pbtt_pkg::hit_t   hit_in,
	output pbtt_pkg::hit_t   hit_out,
	output logic             err_count
);

	logic [63:0]             src_q   [2];
	logic [63:0]             tgt_q   [2];
	logic [1:0]              kind_q  [2];
	logic [63:0]             cnt_q   [2];
	logic [5:0]              fill_q  [2];
	logic [VERSION_BITS-1:0] ver_q   [2];

	logic        sel;
	logic        is_query;
	logic        m;
	logic        hit;
	logic        own;
	logic [1:0]  own_outcome;
	logic [63:0] ver_wide;
	logic [63:0] bits;
	logic        n_ok;
	logic        ovf;
	logic [6:0]  base [2];
	logic [6:0]  sum  [2];

	assign sel      = ({1'b0, cmd.reg_index} == 6'(IDX));
	assign is_query = (cmd.mode == pbtt_pkg::MODE_QRY_FETCH)
		|| (cmd.mode == pbtt_pkg::MODE_QRY_FINAL);
	assign m        = (cmd.mode == pbtt_pkg::MODE_QRY_FINAL);
	assign hit      = (kind_q[m] != pbtt_pkg::KIND_NONE) && (src_q[m] == cmd.address);
	assign own      = hit && !hit_in.found;
	assign ver_wide = 64'(ver_q[m]);

	always_comb begin
		case (kind_q[m])
			pbtt_pkg::KIND_TAKEN: own_outcome = pbtt_pkg::OUT_TAKEN;
			pbtt_pkg::KIND_LOOP: begin
				if (cnt_q[m][63])
					own_outcome = pbtt_pkg::OUT_EXHAUSTED;
				else if (cnt_q[m] != 64'd0)
					own_outcome = pbtt_pkg::OUT_TAKEN;
				else
					own_outcome = pbtt_pkg::OUT_NOT_TAKEN;
			end
			pbtt_pkg::KIND_BITS: begin
				if (fill_q[m] == 6'd0)
					own_outcome = pbtt_pkg::OUT_EXHAUSTED;
				else if (cnt_q[m][0])
					own_outcome = pbtt_pkg::OUT_TAKEN;
				else
					own_outcome = pbtt_pkg::OUT_NOT_TAKEN;
			end
			default: own_outcome = pbtt_pkg::OUT_NONE;
		endcase
	end

	always_comb begin
		hit_out = hit_in;
		if (own) begin
			hit_out.found       = 1'b1;
			hit_out.outcome     = own_outcome;
			hit_out.matched_reg = 5'(IDX);
			hit_out.version     = ver_wide[31:0];
			hit_out.target      = tgt_q[m];
		end
	end

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			base[j] = (kind_q[j] == pbtt_pkg::KIND_BITS) ? {1'b0, fill_q[j]} : 7'd0;
			sum[j]  = base[j] + cmd.bit_count;
		end
	end

	assign n_ok = (cmd.bit_count >= 7'd1) && (cmd.bit_count <= 7'd64);
	assign ovf  = (sum[0] > 7'd63) || (sum[1] > 7'd63);
	assign bits = (cmd.bit_count >= 7'd64) ? cmd.condition_value
		: (cmd.condition_value & ((64'h1 << cmd.bit_count) - 64'h1));
	assign err_count = sel && (cmd.mode == pbtt_pkg::MODE_SET_COND)
		&& (cmd.condition_kind == pbtt_pkg::COND_BITS) && (!n_ok || ovf);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 2; j++) begin
				src_q[j]  <= '0;
				tgt_q[j]  <= '0;
				kind_q[j] <= pbtt_pkg::KIND_NONE;
				cnt_q[j]  <= '0;
				fill_q[j] <= '0;
				ver_q[j]  <= '0;
			end
		end else if (cmd.en) begin
			if (cmd.mode == pbtt_pkg::MODE_COPY) begin
				src_q[0]  <= src_q[1];
				tgt_q[0]  <= tgt_q[1];
				kind_q[0] <= kind_q[1];
				cnt_q[0]  <= cnt_q[1];
				fill_q[0] <= fill_q[1];
				ver_q[0]  <= ver_q[1];
			end else if (is_query) begin
				if (own) begin
					if (kind_q[m] == pbtt_pkg::KIND_LOOP && !cnt_q[m][63])
						cnt_q[m] <= cnt_q[m] - 64'd1;
					else if (kind_q[m] == pbtt_pkg::KIND_BITS && fill_q[m] != 6'd0) begin
						cnt_q[m]  <= cnt_q[m] >> 1;
						fill_q[m] <= fill_q[m] - 6'd1;
					end
				end
			end else if (sel) begin
				for (int j = 0; j < 2; j++) begin
					case (cmd.mode)
						pbtt_pkg::MODE_SET_SRC: begin
							src_q[j]  <= cmd.address;
							kind_q[j] <= pbtt_pkg::KIND_NONE;
							cnt_q[j]  <= '0;
							fill_q[j] <= '0;
							ver_q[j]  <= ver_q[j] + 1'b1;
						end
						pbtt_pkg::MODE_SET_TGT: begin
							tgt_q[j]  <= cmd.address;
							kind_q[j] <= pbtt_pkg::KIND_TAKEN;
							cnt_q[j]  <= '0;
							fill_q[j] <= '0;
							ver_q[j]  <= ver_q[j] + 1'b1;
						end
						pbtt_pkg::MODE_SET_COND: begin
							case (cmd.condition_kind)
								pbtt_pkg::COND_NONE, pbtt_pkg::COND_TAKEN: begin
									kind_q[j] <= cmd.condition_kind[1:0];
									cnt_q[j]  <= '0;
									fill_q[j] <= '0;
									ver_q[j]  <= ver_q[j] + 1'b1;
								end
								pbtt_pkg::COND_LOOP: begin
									kind_q[j] <= pbtt_pkg::KIND_LOOP;
									cnt_q[j]  <= cmd.condition_value;
									fill_q[j] <= '0;
									ver_q[j]  <= ver_q[j] + 1'b1;
								end
								pbtt_pkg::COND_BITS: begin
									if (n_ok && !ovf) begin
										kind_q[j] <= pbtt_pkg::KIND_BITS;
										fill_q[j] <= sum[j][5:0];
										if (kind_q[j] == pbtt_pkg::KIND_BITS)
											cnt_q[j] <= cnt_q[j] | (bits << base[j][5:0]);
										else begin
											cnt_q[j] <= bits;
											ver_q[j] <= ver_q[j] + 1'b1;
										end
									end
								end
								default: ;
							endcase
						end
						default: ;
					endcase
				end
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/pbtt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module pbtt_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         s_tready,
	input wire         m_tvalid,
	input wire         m_tready,
	input wire [103:0] m_tdata,
	input wire [1:0]   m_tuser,
	input wire [31:0]  prdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Result item changed while stalled.");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("Input stalled with an empty output stage.");

	a_err_plain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[102:101] != pbtt_pkg::ERR_OK) |-> (m_tuser == pbtt_pkg::OUT_NONE)
			&& (m_tdata[100:0] == 101'd0))
		else $error("Error item carries query data.");

	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == pbtt_pkg::OUT_NONE) |-> (m_tdata[36:0] == 37'd0))
		else $error("Miss item carries a register or version.");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[31:4] == 28'd0)
		else $error("Register read shows bits beyond its width.");

endmodule

bind precomputed_branch_target_table pbtt_checker u_pbtt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.prdata   (prdata)
);
`default_nettype wire
